// File: rtl/i2cs_pkg.sv
// Package for the I2C master transaction sequencer: word types, command and
// item kind codes, and the bus status codes that drive the transfer.
// No dependencies.
package i2cs_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD        = 2'd0,
        KIND_START_WRITE = 2'd1,
        KIND_START_READ  = 2'd2,
        KIND_STATUS      = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_ADDR  = 3'd3,
        CMD_DATA  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6,
        CMD_CLEAR = 3'd7
    } t_cmd;

    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] load_index;
        logic [7:0] load_value;
        logic [6:0] slave_address;
        logic [6:0] transfer_length;
        logic [7:0] bus_status;
        logic [7:0] received_byte;
    } t_in_word;

    typedef struct packed {
        logic       accepted;
        t_cmd       command;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [5:0] read_index;
        logic [7:0] read_byte;
        logic       busy_now;
        logic       last_success;
        logic       finished;
    } t_out_word;

    // Decoded result held between the control stage and the output register.
    typedef struct packed {
        logic       accepted;
        t_cmd       command;
        logic [7:0] addr_byte;
        logic       use_store;
        logic       store_hit;
        logic       read_valid;
        logic [5:0] read_index;
        logic [7:0] read_byte;
        logic       busy_now;
        logic       last_success;
        logic       finished;
    } t_stage;

endpackage

// File: rtl/i2cs_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on i2cs_pkg.
interface i2cs_in_if;
    logic               valid;
    logic               ready;
    i2cs_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cs_out_if;
    logic                valid;
    logic                ready;
    i2cs_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/i2c_master_transaction_sequencer_top.sv
// Top level of the I2C master transaction sequencer.
// Depends on i2cs_pkg, i2cs_if, i2cs_store, i2cs_ctrl and i2cs_out.
//
//   Channel   Dir   Word                  Handshake
//   i_in      in    i2cs_pkg::t_in_word   valid/ready, taken when both high
//   o_out     out   i2cs_pkg::t_out_word  valid/ready, taken when both high
//
// One word is taken per cycle while the output does not stall; its result is
// registered at the control stage, with the store read, then in the output
// register. Reset clears the transfer state; the byte store is not cleared.
// A stall at the output fills the two stages, then holds the input off.
module i2c_master_transaction_sequencer_top #(
    parameter int STORE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cs_in_if.sink     i_in,
    i2cs_out_if.source  o_out
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic             s1_valid;
    logic             s1_ready;
    i2cs_pkg::t_stage s1;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;

    i2cs_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_s1_ready (s1_ready),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    i2cs_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    i2cs_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (s1_valid),
        .i_s1         (s1),
        .i_store_data (rd_data),
        .o_s1_ready   (s1_ready),
        .o_out        (o_out)
    );

endmodule

// File: rtl/i2cs_store.sv
// Byte store: one write port and one registered read port.
// Depends on nothing outside this file.
module i2cs_store #(
    parameter int STORE_DEPTH = 64,
    parameter int AW          = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/i2cs_ctrl.sv
// Transfer state and status decode; registers one decoded result per word.
// Depends on i2cs_pkg and i2cs_in_if.
module i2cs_ctrl #(
    parameter int STORE_DEPTH = 64,
    parameter int AW          = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cs_in_if.sink            i_in,
    input  logic               i_s1_ready,
    output logic               o_s1_valid,
    output i2cs_pkg::t_stage   o_s1,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [7:0]         o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr
);

    localparam logic [7:0] DEPTH_W = 8'(STORE_DEPTH);

    logic             r_busy, n_busy;
    logic             r_reading, n_reading;
    logic [6:0]       r_target, n_target;
    logic [6:0]       r_len, n_len;
    logic [6:0]       r_pos, n_pos;
    logic             r_ack, n_ack;
    logic             r_success, n_success;
    logic             r_s1_valid;
    i2cs_pkg::t_stage r_s1, n_s1;

    logic             accept;
    logic [7:0]       status;
    logic [7:0]       pos_w;
    logic [7:0]       idx_w;
    logic [6:0]       pos_inc;
    logic             pos_hit;
    logic             rd_item;
    logic             refuse;
    logic             ack_now;
    logic             do_stop;
    logic             do_store;

    assign i_in.ready = !r_s1_valid || i_s1_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign status     = i_in.data.bus_status & i2cs_pkg::STATUS_MASK;
    assign pos_w      = {1'b0, r_pos};
    assign idx_w      = {2'b00, i_in.data.load_index};
    assign pos_inc    = 7'(r_pos + 7'd1);
    assign pos_hit    = pos_w < DEPTH_W;
    assign rd_item    = i_in.data.kind == i2cs_pkg::KIND_START_READ;
    assign refuse     = r_busy || ({1'b0, i_in.data.transfer_length} > DEPTH_W)
                        || (rd_item && i_in.data.transfer_length == 7'd0);

    always_comb begin
        n_busy    = r_busy;
        n_reading = r_reading;
        n_target  = r_target;
        n_len     = r_len;
        n_pos     = r_pos;
        n_ack     = r_ack;
        n_success = r_success;
        ack_now   = r_ack;
        do_stop   = 1'b0;
        do_store  = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = idx_w[AW-1:0];
        o_wr_data = i_in.data.load_value;

        n_s1            = '0;
        n_s1.accepted   = 1'b1;
        n_s1.command    = i2cs_pkg::CMD_NONE;
        n_s1.read_index = r_pos[5:0];
        n_s1.read_byte  = i_in.data.received_byte;

        unique case (i_in.data.kind)
            i2cs_pkg::KIND_LOAD: begin
                o_wr_en = idx_w < DEPTH_W;
            end
            i2cs_pkg::KIND_START_WRITE, i2cs_pkg::KIND_START_READ: begin
                if (refuse) begin
                    n_s1.accepted = 1'b0;
                end else begin
                    n_target     = i_in.data.slave_address;
                    n_reading    = rd_item;
                    n_len        = i_in.data.transfer_length;
                    n_pos        = 7'd0;
                    n_busy       = 1'b1;
                    n_s1.command = i2cs_pkg::CMD_START;
                end
            end
            default: begin
                unique case (status) inside
                    i2cs_pkg::ST_START, i2cs_pkg::ST_RESTART: begin
                        n_s1.command   = i2cs_pkg::CMD_ADDR;
                        n_s1.addr_byte = {r_target, r_reading};
                    end
                    i2cs_pkg::ST_MT_SLA_ACK, i2cs_pkg::ST_MT_DATA_ACK: begin
                        n_success = 1'b1;
                        if (r_pos < r_len) begin
                            n_s1.command   = i2cs_pkg::CMD_DATA;
                            n_s1.use_store = 1'b1;
                            n_s1.store_hit = pos_hit;
                            n_pos          = pos_inc;
                        end else begin
                            do_stop = 1'b1;
                        end
                    end
                    i2cs_pkg::ST_MR_SLA_ACK: begin
                        n_success    = 1'b1;
                        n_ack        = r_len != 7'd1;
                        n_s1.command = n_ack ? i2cs_pkg::CMD_ACK : i2cs_pkg::CMD_NACK;
                    end
                    i2cs_pkg::ST_MR_DATA_ACK: begin
                        n_success = 1'b1;
                        do_store  = 1'b1;
                        n_pos     = pos_inc;
                        if (pos_inc == r_len) begin
                            do_stop = 1'b1;
                        end else begin
                            if (({1'b0, pos_inc} + 8'd1) == {1'b0, r_len}) begin
                                ack_now = 1'b0;
                            end
                            n_ack        = ack_now;
                            n_s1.command = ack_now ? i2cs_pkg::CMD_ACK
                                                   : i2cs_pkg::CMD_NACK;
                        end
                    end
                    i2cs_pkg::ST_MR_DATA_NACK: begin
                        n_success = 1'b1;
                        do_store  = 1'b1;
                        n_pos     = pos_inc;
                        do_stop   = 1'b1;
                    end
                    i2cs_pkg::ST_MT_SLA_NACK, i2cs_pkg::ST_MT_DATA_NACK,
                    i2cs_pkg::ST_ARB_LOST, i2cs_pkg::ST_MR_SLA_NACK: begin
                        n_success = 1'b0;
                        do_stop   = 1'b1;
                    end
                    default: begin
                        n_s1.command = i2cs_pkg::CMD_CLEAR;
                    end
                endcase
            end
        endcase

        if (do_store && pos_hit) begin
            o_wr_en         = 1'b1;
            o_wr_addr       = pos_w[AW-1:0];
            o_wr_data       = i_in.data.received_byte;
            n_s1.read_valid = 1'b1;
        end
        if (!n_s1.read_valid) begin
            n_s1.read_index = 6'd0;
            n_s1.read_byte  = 8'd0;
        end
        if (do_stop) begin
            n_s1.command  = i2cs_pkg::CMD_STOP;
            n_s1.finished = 1'b1;
            n_busy        = 1'b0;
        end

        n_s1.busy_now     = n_busy;
        n_s1.last_success = n_success;
        o_wr_en           = o_wr_en && accept;
    end

    assign o_rd_en   = accept && pos_hit;
    assign o_rd_addr = pos_w[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_reading  <= 1'b0;
            r_target   <= 7'd0;
            r_len      <= 7'd0;
            r_pos      <= 7'd0;
            r_ack      <= 1'b0;
            r_success  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy    <= n_busy;
                r_reading <= n_reading;
                r_target  <= n_target;
                r_len     <= n_len;
                r_pos     <= n_pos;
                r_ack     <= n_ack;
                r_success <= n_success;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

// File: rtl/i2cs_out.sv
// Output register: picks the bus byte (store or address) and holds the result.
// Depends on i2cs_pkg and i2cs_out_if.
module i2cs_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s1_valid,
    input  i2cs_pkg::t_stage i_s1,
    input  logic [7:0]       i_store_data,
    output logic             o_s1_ready,
    i2cs_out_if.source       o_out
);

    logic                r_valid;
    i2cs_pkg::t_out_word r_word, n_word;

    assign o_s1_ready = !r_valid || o_out.ready;

    always_comb begin
        n_word.accepted     = i_s1.accepted;
        n_word.command      = i_s1.command;
        n_word.read_valid   = i_s1.read_valid;
        n_word.read_index   = i_s1.read_index;
        n_word.read_byte    = i_s1.read_byte;
        n_word.busy_now     = i_s1.busy_now;
        n_word.last_success = i_s1.last_success;
        n_word.finished     = i_s1.finished;
        if (i_s1.use_store) begin
            n_word.bus_byte = i_s1.store_hit ? i_store_data : 8'd0;
        end else begin
            n_word.bus_byte = i_s1.addr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s1_ready) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_ready && i_s1_valid) begin
            r_word <= n_word;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_word;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_transaction_sequencer_top: directed words,
// then state-aware random transfers under random backpressure, checked by a predictor.
// Depends on i2cs_pkg, i2cs_if and the RTL of the sequencer.
module testbench;

    localparam int RANDOM_WORDS = 1800;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam bit TYPED        = 1'b1;
    localparam bit PREDICTED    = 1'b0;
    localparam i2cs_pkg::t_out_word NO_RESULT = '0;

    typedef struct packed {
        i2cs_pkg::t_in_word  word;
        logic                typed;
        i2cs_pkg::t_out_word result;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cs_in_if  word_ch ();
    i2cs_out_if res_ch ();

    i2c_master_transaction_sequencer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_ch),
        .o_out   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    logic           xfer_busy   = 1'b0;
    logic           xfer_read   = 1'b0;
    logic [6:0]     xfer_target = '0;
    logic [6:0]     xfer_length = '0;
    logic [6:0]     xfer_pos    = '0;
    logic           xfer_ack    = 1'b0;
    logic           xfer_ok     = 1'b0;
    logic [7:0]     byte_image  [64];
    bit             byte_loaded [64];
    i2cs_pkg::t_cmd last_command = i2cs_pkg::CMD_NONE;
    int             flood_left   = 0;

    i2cs_pkg::t_out_word pending_results [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        tx_idle_pct    = 10;
    int        rx_idle_pct    = 53;
    logic      hold_go        = 1'b0;
    logic      hold_done      = 1'b0;
    int        hold_count     = 0;

    function automatic i2cs_pkg::t_out_word sequence_step(i2cs_pkg::t_in_word w);
        i2cs_pkg::t_out_word r;
        logic [7:0]          code;
        logic                stop_now;
        r = '0;
        r.accepted = 1'b1;
        stop_now = 1'b0;
        code = w.bus_status & i2cs_pkg::STATUS_MASK;
        case (w.kind)
            i2cs_pkg::KIND_LOAD: begin
                byte_image[w.load_index]  = w.load_value;
                byte_loaded[w.load_index] = 1'b1;
            end
            i2cs_pkg::KIND_START_WRITE, i2cs_pkg::KIND_START_READ: begin
                if (xfer_busy || w.transfer_length > 7'd64
                        || (w.kind == i2cs_pkg::KIND_START_READ
                            && w.transfer_length == 7'd0)) begin
                    r.accepted = 1'b0;
                end else begin
                    xfer_target = w.slave_address;
                    xfer_read   = (w.kind == i2cs_pkg::KIND_START_READ);
                    xfer_length = w.transfer_length;
                    xfer_pos    = '0;
                    xfer_busy   = 1'b1;
                    r.command   = i2cs_pkg::CMD_START;
                end
            end
            default: begin
                case (code)
                    i2cs_pkg::ST_START, i2cs_pkg::ST_RESTART: begin
                        r.command  = i2cs_pkg::CMD_ADDR;
                        r.bus_byte = {xfer_target, xfer_read};
                    end
                    i2cs_pkg::ST_MT_SLA_ACK, i2cs_pkg::ST_MT_DATA_ACK: begin
                        xfer_ok = 1'b1;
                        if (xfer_pos < xfer_length) begin
                            r.command  = i2cs_pkg::CMD_DATA;
                            r.bus_byte = (xfer_pos < 64) ? byte_image[xfer_pos[5:0]] : 8'h00;
                            xfer_pos   = xfer_pos + 7'd1;
                        end else begin
                            stop_now = 1'b1;
                        end
                    end
                    i2cs_pkg::ST_MR_SLA_ACK: begin
                        xfer_ok   = 1'b1;
                        xfer_ack  = (xfer_length != 7'd1);
                        r.command = xfer_ack ? i2cs_pkg::CMD_ACK : i2cs_pkg::CMD_NACK;
                    end
                    i2cs_pkg::ST_MR_DATA_ACK, i2cs_pkg::ST_MR_DATA_NACK: begin
                        xfer_ok = 1'b1;
                        if (xfer_pos < 64) begin
                            byte_image[xfer_pos[5:0]]  = w.received_byte;
                            byte_loaded[xfer_pos[5:0]] = 1'b1;
                            r.read_valid = 1'b1;
                            r.read_index = xfer_pos[5:0];
                            r.read_byte  = w.received_byte;
                        end
                        xfer_pos = xfer_pos + 7'd1;
                        if (code == i2cs_pkg::ST_MR_DATA_NACK || xfer_pos == xfer_length) begin
                            stop_now = 1'b1;
                        end else begin
                            if (int'(xfer_pos) + 1 == int'(xfer_length)) xfer_ack = 1'b0;
                            r.command = xfer_ack ? i2cs_pkg::CMD_ACK : i2cs_pkg::CMD_NACK;
                        end
                    end
                    i2cs_pkg::ST_MT_SLA_NACK, i2cs_pkg::ST_MT_DATA_NACK,
                    i2cs_pkg::ST_ARB_LOST, i2cs_pkg::ST_MR_SLA_NACK: begin
                        xfer_ok  = 1'b0;
                        stop_now = 1'b1;
                    end
                    default: r.command = i2cs_pkg::CMD_CLEAR;
                endcase
            end
        endcase
        if (stop_now) begin
            r.command  = i2cs_pkg::CMD_STOP;
            r.finished = 1'b1;
            xfer_busy  = 1'b0;
        end
        r.busy_now     = xfer_busy;
        r.last_success = xfer_ok;
        return r;
    endfunction

    function automatic i2cs_pkg::t_in_word noise_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(i2cs_pkg::t_in_word)-1:0];
    endfunction

    function automatic i2cs_pkg::t_in_word load_word(logic [5:0] idx, logic [7:0] value);
        i2cs_pkg::t_in_word w;
        w = noise_word();
        w.kind       = i2cs_pkg::KIND_LOAD;
        w.load_index = idx;
        w.load_value = value;
        return w;
    endfunction

    function automatic i2cs_pkg::t_in_word start_word(i2cs_pkg::t_kind k, logic [6:0] addr,
                                                      logic [6:0] len);
        i2cs_pkg::t_in_word w;
        w = noise_word();
        w.kind            = k;
        w.slave_address   = addr;
        w.transfer_length = len;
        return w;
    endfunction

    function automatic i2cs_pkg::t_in_word status_word(logic [7:0] code, logic [7:0] rx);
        i2cs_pkg::t_in_word w;
        w = noise_word();
        w.kind          = i2cs_pkg::KIND_STATUS;
        w.bus_status    = {code[7:3], w.bus_status[2:0]};
        w.received_byte = rx;
        return w;
    endfunction

    function automatic i2cs_pkg::t_out_word plain_result(logic acc, i2cs_pkg::t_cmd cmd,
                                                         logic [7:0] bus_byte, logic busy,
                                                         logic ok, logic fin);
        i2cs_pkg::t_out_word r;
        r = '0;
        r.accepted     = acc;
        r.command      = cmd;
        r.bus_byte     = bus_byte;
        r.busy_now     = busy;
        r.last_success = ok;
        r.finished     = fin;
        return r;
    endfunction

    // While busy, mostly the status the bus would report next, else errors, loads,
    // starts while busy and raw status noise; while idle, loads, starts and noise.
    function automatic i2cs_pkg::t_in_word next_word();
        i2cs_pkg::t_in_word w;
        logic [7:0]         code;
        int                 pick;
        w = noise_word();
        pick = $urandom_range(0, 99);
        code = w.bus_status;
        if (flood_left != 0) begin
            flood_left--;
            w.kind = i2cs_pkg::KIND_STATUS;
            code = i2cs_pkg::ST_MR_DATA_ACK;
        end else if (!xfer_busy) begin
            if ($urandom_range(0, 299) == 0) begin
                flood_left = $urandom_range(60, 140);
                w.kind = i2cs_pkg::KIND_STATUS;
                code = i2cs_pkg::ST_MR_DATA_ACK;
            end else if (pick < 30) begin
                w.kind = i2cs_pkg::KIND_LOAD;
            end else if (pick < 86) begin
                w.kind = (pick < 58) ? i2cs_pkg::KIND_START_WRITE : i2cs_pkg::KIND_START_READ;
                if ($urandom_range(0, 19) == 0) begin
                    w.transfer_length = 7'd64;
                end else begin
                    w.transfer_length = 7'($urandom_range(
                        w.kind == i2cs_pkg::KIND_START_WRITE ? 0 : 1, 8));
                end
            end else if (pick < 91) begin
                w.kind = pick[1] ? i2cs_pkg::KIND_START_WRITE : i2cs_pkg::KIND_START_READ;
                w.transfer_length = (pick[0] && w.kind == i2cs_pkg::KIND_START_READ)
                                    ? 7'd0 : 7'($urandom_range(65, 127));
            end else begin
                w.kind = i2cs_pkg::KIND_STATUS;
            end
        end else if (pick < 85) begin
            w.kind = i2cs_pkg::KIND_STATUS;
            case (last_command)
                i2cs_pkg::CMD_START: code = pick[0] ? i2cs_pkg::ST_START : i2cs_pkg::ST_RESTART;
                i2cs_pkg::CMD_ADDR:  code = xfer_read ? i2cs_pkg::ST_MR_SLA_ACK
                                                      : i2cs_pkg::ST_MT_SLA_ACK;
                i2cs_pkg::CMD_DATA:  code = i2cs_pkg::ST_MT_DATA_ACK;
                i2cs_pkg::CMD_ACK:   code = i2cs_pkg::ST_MR_DATA_ACK;
                i2cs_pkg::CMD_NACK:  code = i2cs_pkg::ST_MR_DATA_NACK;
                default:             code = i2cs_pkg::ST_START;
            endcase
        end else if (pick < 90) begin
            w.kind = i2cs_pkg::KIND_STATUS;
            case ($urandom_range(0, 3))
                0:       code = i2cs_pkg::ST_MT_SLA_NACK;
                1:       code = i2cs_pkg::ST_MT_DATA_NACK;
                2:       code = i2cs_pkg::ST_ARB_LOST;
                default: code = i2cs_pkg::ST_MR_SLA_NACK;
            endcase
        end else if (pick < 94) begin
            w.kind = i2cs_pkg::KIND_LOAD;
        end else if (pick < 97) begin
            w.kind = pick[0] ? i2cs_pkg::KIND_START_WRITE : i2cs_pkg::KIND_START_READ;
        end else begin
            w.kind = i2cs_pkg::KIND_STATUS;
        end
        w.bus_status = {code[7:3], w.bus_status[2:0]};
        code = w.bus_status & i2cs_pkg::STATUS_MASK;
        // A send from a store entry that was never written is replaced by a load of it.
        if (w.kind == i2cs_pkg::KIND_STATUS
                && (code == i2cs_pkg::ST_MT_SLA_ACK || code == i2cs_pkg::ST_MT_DATA_ACK)
                && xfer_pos < xfer_length && xfer_pos < 64 && !byte_loaded[xfer_pos[5:0]]) begin
            w.kind       = i2cs_pkg::KIND_LOAD;
            w.load_index = xfer_pos[5:0];
        end
        return w;
    endfunction

    task automatic send_word(input i2cs_pkg::t_in_word w, input logic typed,
                             input i2cs_pkg::t_out_word result);
        i2cs_pkg::t_out_word r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            word_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_ch.valid <= 1'b1;
        word_ch.data  <= w;
        do @(posedge i_clk); while (!word_ch.ready);
        r = sequence_step(w);
        if (r.command != i2cs_pkg::CMD_NONE) last_command = r.command;
        pending_results.push_back(typed ? result : r);
    endtask

    task automatic note_failure(input string what, input i2cs_pkg::t_out_word want,
                                input i2cs_pkg::t_out_word got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s at cycle %0d: expected %h, got %h", what, cycle_count, want, got);
        end
    endtask

    function automatic bit words_differ(i2cs_pkg::t_out_word e, i2cs_pkg::t_out_word a);
        return e.accepted !== a.accepted || e.command !== a.command
            || e.bus_byte !== a.bus_byte || e.read_valid !== a.read_valid
            || e.read_index !== a.read_index || e.read_byte !== a.read_byte
            || e.busy_now !== a.busy_now || e.last_success !== a.last_success
            || e.finished !== a.finished;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("i2c_master_transaction_sequencer_top: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            if (hold_count < HOLD_CYCLES) begin
                res_ch.ready <= 1'b0;
                hold_count   <= hold_count + 1;
            end else begin
                res_ch.ready <= 1'b1;
                hold_done    <= 1'b1;
            end
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                note_failure("Unexpected result", NO_RESULT, res_ch.data);
            end else if (words_differ(pending_results[0], res_ch.data)) begin
                note_failure("Result mismatch", pending_results[0], res_ch.data);
                void'(pending_results.pop_front());
            end else begin
                void'(pending_results.pop_front());
            end
        end
    end

    initial begin
        t_row plan [$];
        i_rst_n       <= 1'b0;
        word_ch.valid <= 1'b0;
        word_ch.data  <= '0;

        plan.push_back({status_word(i2cs_pkg::ST_START, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_ADDR, 8'h00, 0, 0, 0)});
        plan.push_back({load_word(6'd0, 8'hA5), TYPED,
                        plain_result(1, i2cs_pkg::CMD_NONE, 8'h00, 0, 0, 0)});
        plan.push_back({load_word(6'd1, 8'h5A), TYPED,
                        plain_result(1, i2cs_pkg::CMD_NONE, 8'h00, 0, 0, 0)});
        plan.push_back({load_word(6'd63, 8'hFF), TYPED,
                        plain_result(1, i2cs_pkg::CMD_NONE, 8'h00, 0, 0, 0)});
        plan.push_back({start_word(i2cs_pkg::KIND_START_READ, 7'h7F, 7'd0), TYPED,
                        plain_result(0, i2cs_pkg::CMD_NONE, 8'h00, 0, 0, 0)});
        plan.push_back({start_word(i2cs_pkg::KIND_START_WRITE, 7'h7F, 7'd127), TYPED,
                        plain_result(0, i2cs_pkg::CMD_NONE, 8'h00, 0, 0, 0)});
        plan.push_back({start_word(i2cs_pkg::KIND_START_WRITE, 7'h7F, 7'd2), TYPED,
                        plain_result(1, i2cs_pkg::CMD_START, 8'h00, 1, 0, 0)});
        plan.push_back({start_word(i2cs_pkg::KIND_START_READ, 7'h2A, 7'd3), TYPED,
                        plain_result(0, i2cs_pkg::CMD_NONE, 8'h00, 1, 0, 0)});
        plan.push_back({status_word(i2cs_pkg::ST_RESTART, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_ADDR, 8'hFE, 1, 0, 0)});
        plan.push_back({status_word(i2cs_pkg::ST_MT_SLA_ACK, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_DATA, 8'hA5, 1, 1, 0)});
        plan.push_back({load_word(6'd2, 8'h00), PREDICTED, NO_RESULT});
        plan.push_back({status_word(i2cs_pkg::ST_MT_DATA_ACK, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_DATA, 8'h5A, 1, 1, 0)});
        plan.push_back({status_word(i2cs_pkg::ST_MT_DATA_ACK, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_STOP, 8'h00, 0, 1, 1)});
        plan.push_back({status_word(8'hF8, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_CLEAR, 8'h00, 0, 1, 0)});
        plan.push_back({start_word(i2cs_pkg::KIND_START_READ, 7'h55, 7'd1), TYPED,
                        plain_result(1, i2cs_pkg::CMD_START, 8'h00, 1, 1, 0)});
        plan.push_back({status_word(i2cs_pkg::ST_START, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_ADDR, 8'hAB, 1, 1, 0)});
        plan.push_back({status_word(i2cs_pkg::ST_MR_SLA_ACK, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_NACK, 8'h00, 1, 1, 0)});
        plan.push_back({status_word(i2cs_pkg::ST_MR_DATA_NACK, 8'hFF), PREDICTED, NO_RESULT});
        plan.push_back({start_word(i2cs_pkg::KIND_START_READ, 7'h00, 7'd64), PREDICTED,
                        NO_RESULT});
        plan.push_back({status_word(i2cs_pkg::ST_MR_SLA_ACK, 8'h00), PREDICTED, NO_RESULT});
        plan.push_back({status_word(i2cs_pkg::ST_MR_DATA_ACK, 8'h00), PREDICTED, NO_RESULT});
        plan.push_back({status_word(i2cs_pkg::ST_MR_SLA_NACK, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_STOP, 8'h00, 0, 0, 1)});
        plan.push_back({start_word(i2cs_pkg::KIND_START_WRITE, 7'h01, 7'd0), PREDICTED,
                        NO_RESULT});
        plan.push_back({status_word(i2cs_pkg::ST_MT_SLA_NACK, 8'h00), TYPED,
                        plain_result(1, i2cs_pkg::CMD_STOP, 8'h00, 0, 0, 1)});
        plan.push_back({status_word(i2cs_pkg::ST_MT_DATA_NACK, 8'h00), PREDICTED, NO_RESULT});
        plan.push_back({status_word(i2cs_pkg::ST_ARB_LOST, 8'h00), PREDICTED, NO_RESULT});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].result);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                tx_idle_pct = 53;
                rx_idle_pct = 10;
                while (pending_results.size() != 0) begin
                    word_ch.valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            if (n == 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_go <= 1'b1;
            end
            send_word(next_word(), PREDICTED, NO_RESULT);
        end
        word_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("i2c_master_transaction_sequencer_top: match");
        end else begin
            $display("i2c_master_transaction_sequencer_top: mismatch");
        end
        $finish;
    end
endmodule
